[sv/bclce_pkg.sv]
package bclce_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_ALLOC,
        ST_DONE
    } t_state;

    localparam logic [0:0] REG_BLOCK_SIZE_LOG2 = 1'b0;
    localparam logic [0:0] REG_MAX_BLOCKS      = 1'b1;

    localparam logic [4:0] LOG2_MIN   = 5'd9;
    localparam logic [4:0] LOG2_MAX   = 5'd16;
    localparam logic [4:0] LOG2_RESET = 5'd12;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture command and look up
        logic evict;   // drop victim
        logic alloc;   // allocate tag at free slot
        logic finish;  // apply hit/write/flush effects, latch result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic full;        // held >= limit
        logic has_victim;
        logic has_free;
        logic [1:0] cmd;
    } t_dp_stat;

endpackage

[sv/block_cache_lru_clean_evict.sv]
// Channel | Signals                                        | Dir
// in      | i_valid, o_stall, i_cmd, i_offset, i_range_size | in
// out     | o_valid, i_stall, o_status .. o_writes_count    | out
// cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
// A word passes through lookup, evict (only on a read or write miss while full), allocate (on any
// read or write miss) and commit; the controller walks these steps in that order.
// Synchronous active-low reset clears all valid and dirty bits and counters at once.
// o_stall is high from acceptance until the result is latched; a stalled result
// holds the commit step, and the next word is taken while a result still waits.
module block_cache_lru_clean_evict #(
    parameter int CAPACITY    = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_offset,
    input  logic [31:0] i_range_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic        o_was_hit,
    output logic [31:0] o_hits_count,
    output logic [31:0] o_misses_count,
    output logic [6:0]  o_blocks_held,
    output logic [31:0] o_reads_count,
    output logic [31:0] o_writes_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    logic [4:0] r_bs_log2;
    logic [6:0] r_max_blocks;
    bclce_pkg::t_dp_cmd  dp_cmd;
    bclce_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs_log2    <= bclce_pkg::LOG2_RESET;
            r_max_blocks <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bclce_pkg::REG_BLOCK_SIZE_LOG2: r_bs_log2    <= i_cfg_data[4:0];
                bclce_pkg::REG_MAX_BLOCKS:      r_max_blocks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bclce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    bclce_dp #(
        .CAPACITY    (CAPACITY),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cmd_code     (i_cmd),
        .i_offset       (i_offset),
        .i_range_size   (i_range_size),
        .i_bs_log2      (r_bs_log2),
        .i_max_blocks   (r_max_blocks),
        .o_status       (o_status),
        .o_was_hit      (o_was_hit),
        .o_hits_count   (o_hits_count),
        .o_misses_count (o_misses_count),
        .o_blocks_held  (o_blocks_held),
        .o_reads_count  (o_reads_count),
        .o_writes_count (o_writes_count)
    );

    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !o_stall) else $error("config write while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_stat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_hits_count)) else $error("result changed");

endmodule

[sv/bclce_ctrl.sv]
module bclce_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  bclce_pkg::t_dp_stat  i_stat,
    output bclce_pkg::t_dp_cmd   o_cmd
);

    bclce_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bclce_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        logic is_alloc_cmd;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        is_alloc_cmd = 1'b0;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            bclce_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bclce_pkg::ST_LOOKUP;
                end
            end
            bclce_pkg::ST_LOOKUP: begin
                is_alloc_cmd = (i_stat.cmd == bclce_pkg::CMD_READ) ||
                               (i_stat.cmd == bclce_pkg::CMD_WRITE);
                if (is_alloc_cmd && !i_stat.hit) begin
                    n_state = i_stat.full ? bclce_pkg::ST_EVICT : bclce_pkg::ST_ALLOC;
                end else begin
                    n_state = bclce_pkg::ST_DONE;
                end
            end
            bclce_pkg::ST_EVICT: begin
                o_cmd.evict = i_stat.has_victim;
                n_state     = bclce_pkg::ST_ALLOC;
            end
            bclce_pkg::ST_ALLOC: begin
                o_cmd.alloc = !i_stat.full && i_stat.has_free;
                n_state     = bclce_pkg::ST_DONE;
            end
            bclce_pkg::ST_DONE: begin
                if (!n_out_valid) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = bclce_pkg::ST_IDLE;
                end
            end
            default: n_state = bclce_pkg::ST_IDLE;
        endcase
    end

    assign o_stall = (r_state != bclce_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid) else $error("finish without valid");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == bclce_pkg::ST_IDLE) else $error("load outside idle");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("multiple commands");

endmodule

[sv/bclce_dp.sv]
module bclce_dp #(
    parameter int CAPACITY    = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bclce_pkg::t_dp_cmd  i_cmd,
    output bclce_pkg::t_dp_stat o_stat,
    input  logic [1:0]          i_cmd_code,
    input  logic [31:0]         i_offset,
    input  logic [31:0]         i_range_size,
    input  logic [4:0]          i_bs_log2,
    input  logic [6:0]          i_max_blocks,
    output logic                o_status,
    output logic                o_was_hit,
    output logic [31:0]         o_hits_count,
    output logic [31:0]         o_misses_count,
    output logic [6:0]          o_blocks_held,
    output logic [31:0]         o_reads_count,
    output logic [31:0]         o_writes_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    localparam int P  = 1 << IW;

    logic [CAPACITY-1:0] r_valid, r_dirty;
    logic [31:0]         r_tag [CAPACITY];
    logic [IW-1:0]       r_rank [CAPACITY];
    logic [CW-1:0]       r_held;
    logic [6:0]          r_held_out;
    logic [31:0]         r_hits, r_misses, r_reads, r_writes;
    logic [1:0]          r_cmd;
    logic [32:0]         r_off, r_end;
    logic [31:0]         r_tagq;
    logic [16:0]         r_bs;
    logic                r_hit, r_status;
    logic                r_alloced;

    logic [4:0]  eff_log2;
    logic [31:0] off_m, mask;
    logic [8:0]  lim;

    always_comb begin
        if (i_bs_log2 < bclce_pkg::LOG2_MIN)      eff_log2 = bclce_pkg::LOG2_MIN;
        else if (i_bs_log2 > bclce_pkg::LOG2_MAX) eff_log2 = bclce_pkg::LOG2_MAX;
        else                                      eff_log2 = i_bs_log2;
        off_m = '0;
        off_m[OW-1:0] = i_offset[OW-1:0];
        mask = ~((32'd1 << eff_log2) - 32'd1);
        lim = (9'(i_max_blocks) > 9'(CAPACITY)) ? 9'(CAPACITY) : 9'(i_max_blocks);
    end

    // lookup and free-slot searches over registered state
    logic              hit_any, vic_any, free_any;
    logic [IW-1:0]     hit_idx, vic_idx, free_idx;
    always_comb begin
        hit_any = 1'b0; hit_idx = '0;
        free_any = 1'b0; free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_valid[i] && r_tag[i] == r_tagq) begin
                hit_any = 1'b1; hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_any = 1'b1; free_idx = IW'(i);
            end
        end
    end

    // victim: clean block of highest rank, balanced tree; left wins ties
    logic          vt_ok   [1:2*P-1];
    logic [IW-1:0] vt_rank [1:2*P-1];
    logic [IW-1:0] vt_idx  [1:2*P-1];
    always_comb begin
        for (int i = 0; i < P; i++) begin
            vt_ok[P+i]   = 1'b0;
            vt_rank[P+i] = '0;
            vt_idx[P+i]  = IW'(i);
        end
        for (int i = 0; i < CAPACITY; i++) begin
            vt_ok[P+i]   = r_valid[i] && !r_dirty[i];
            vt_rank[P+i] = r_rank[i];
        end
        for (int n = P - 1; n >= 1; n--) begin
            if (vt_ok[2*n+1] && (!vt_ok[2*n] || vt_rank[2*n+1] > vt_rank[2*n])) begin
                vt_ok[n]   = 1'b1;
                vt_rank[n] = vt_rank[2*n+1];
                vt_idx[n]  = vt_idx[2*n+1];
            end else begin
                vt_ok[n]   = vt_ok[2*n];
                vt_rank[n] = vt_rank[2*n];
                vt_idx[n]  = vt_idx[2*n];
            end
        end
        vic_any = vt_ok[1];
        vic_idx = vt_idx[1];
    end

    assign o_stat.hit        = hit_any;
    assign o_stat.full       = 9'(r_held) >= lim;
    assign o_stat.has_victim = vic_any;
    assign o_stat.has_free   = free_any;
    assign o_stat.cmd        = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dirty  <= '0;
            r_held   <= '0;
            r_held_out <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_reads  <= '0;
            r_writes <= '0;
            r_alloced <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmd   <= i_cmd_code;
                r_tagq  <= off_m & mask;
                r_off   <= {1'b0, off_m};
                r_end   <= {1'b0, off_m} + {1'b0, i_range_size};
                r_bs    <= 17'd1 << eff_log2;
                r_alloced <= 1'b0;
            end
            if (i_cmd.evict) begin
                r_valid[vic_idx] <= 1'b0;
                r_held <= r_held - CW'(1);
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_valid[i] && r_rank[i] > r_rank[vic_idx]) r_rank[i] <= r_rank[i] - IW'(1);
                end
            end
            if (i_cmd.alloc) begin
                r_valid[free_idx] <= 1'b1;
                r_dirty[free_idx] <= 1'b0;
                r_tag[free_idx]   <= r_tagq;
                r_rank[free_idx]  <= '0;
                r_held            <= r_held + CW'(1);
                r_alloced         <= 1'b1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_valid[i]) r_rank[i] <= r_rank[i] + IW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_hit <= 1'b0;
                r_status <= 1'b0;
                r_held_out <= 7'(r_held);
                unique case (bclce_pkg::t_cmd'(r_cmd))
                    bclce_pkg::CMD_READ, bclce_pkg::CMD_WRITE: begin
                        if (hit_any) begin
                            r_hit <= !r_alloced;
                            if (!r_alloced) begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (r_valid[i] && r_rank[i] < r_rank[hit_idx])
                                        r_rank[i] <= r_rank[i] + IW'(1);
                                end
                                r_rank[hit_idx] <= '0;
                            end
                            if (r_cmd == bclce_pkg::CMD_READ) begin
                                r_reads <= r_reads + 32'd1;
                                if (r_alloced) r_misses <= r_misses + 32'd1;
                                else           r_hits   <= r_hits + 32'd1;
                            end else begin
                                r_dirty[hit_idx] <= 1'b1;
                                r_writes <= r_writes + 32'd1;
                            end
                        end else begin
                            r_status <= 1'b1;
                            if (r_cmd == bclce_pkg::CMD_READ) r_misses <= r_misses + 32'd1;
                        end
                    end
                    bclce_pkg::CMD_FLUSH: begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (r_valid[i] && {1'b0, r_tag[i]} < r_end &&
                                ({1'b0, r_tag[i]} + {16'd0, r_bs}) > r_off)
                                r_dirty[i] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_status       = r_status;
    assign o_was_hit      = r_hit;
    assign o_hits_count   = r_hits;
    assign o_misses_count = r_misses;
    assign o_blocks_held  = r_held_out;
    assign o_reads_count  = r_reads;
    assign o_writes_count = r_writes;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_held} <= (CW+1)'(CAPACITY)) else $error("held above capacity");
    a_held_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_held)) else $error("held mismatch");
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> free_any) else $error("alloc without free slot");

endmodule
